// File: sv/id_allocator_free_list_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ID allocator
// The macros expect signals named clk and rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ID_ALLOCATOR_FREE_LIST_TOP_ASSERT_SVH
`define ID_ALLOCATOR_FREE_LIST_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define IDAFL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define IDAFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/idafl_pkg.sv
// ----------------------------------------------------------------------------
// idafl_pkg
// Shared widths, operation codes and structs of the ID allocator.
// ----------------------------------------------------------------------------
package idafl_pkg;

    localparam int ID_W       = 8;
    localparam int NEXT_W     = 9;
    localparam int ID_LIMIT   = 255;
    localparam int MAX_ID_DEF = 255;

    localparam logic [1:0] FUNC_CLAIM   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;

    // Read request to the entry store.
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
    } rd_req_t;

    // Write to the status memory: flags and backward link of one entry.
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
        logic            assigned;
        logic            on_free;
        logic [ID_W-1:0] prev;
    } stat_wr_t;

    // Write to the forward link memory.
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] addr;
        logic [ID_W-1:0] next;
    } link_wr_t;

    // One entry as read back from the store.
    typedef struct packed {
        logic            assigned;
        logic            on_free;
        logic [ID_W-1:0] prev;
        logic [ID_W-1:0] next;
    } entry_t;

    typedef struct packed {
        logic              freed;
        logic              is_assigned;
        logic              is_available;
        logic [NEXT_W-1:0] next_id;
        logic [ID_W-1:0]   highest_id;
    } rsp_t;

endpackage

// File: sv/idafl_req_if.sv
// ----------------------------------------------------------------------------
// idafl_req_if
// Request channel: operation code and identifier.
// ----------------------------------------------------------------------------
interface idafl_req_if
    import idafl_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [1:0]      func;
    logic [ID_W-1:0] id;

    modport source (output valid, output func, output id, input ready);
    modport sink (input valid, input func, input id, output ready);
endinterface

// File: sv/idafl_rsp_if.sv
// ----------------------------------------------------------------------------
// idafl_rsp_if
// Result channel: status of the identifier and allocator summary.
// ----------------------------------------------------------------------------
interface idafl_rsp_if
    import idafl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              freed;
    logic              is_assigned;
    logic              is_available;
    logic [NEXT_W-1:0] next_id;
    logic [ID_W-1:0]   highest_id;

    modport source (output valid, output freed, output is_assigned, output is_available,
                    output next_id, output highest_id, input ready);
    modport sink (input valid, input freed, input is_assigned, input is_available,
                  input next_id, input highest_id, output ready);
endinterface

// File: sv/id_allocator_free_list_top.sv
// ----------------------------------------------------------------------------
// id_allocator_free_list_top
// ID allocator with an ordered free list kept as a linked list in memory.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                            Beat
//  req      in   func, id                                           one operation
//  rsp      out  freed, is_assigned, is_available, next_id, highest  one result
//
// A query, a release or a claim at or below the highest passes through accept,
// entry read, optional write and result. A claim above the highest adds a skip
// step per skipped identifier, since the status memory has one write port
// and each skipped identifier is appended there in a step of its own.
// Reset clears the flags through per-entry valid bits, so no clearing pass runs.
// A held result stalls only the last step; the next beat waits for it to load.
// ----------------------------------------------------------------------------
module id_allocator_free_list_top
    import idafl_pkg::*;
#(
    parameter int MAX_ID = MAX_ID_DEF
) (
    input  logic clk,
    input  logic rst_n,
    idafl_req_if.sink   req,
    idafl_rsp_if.source rsp
);

    rd_req_t  rd;
    stat_wr_t stat_wr;
    link_wr_t link_wr;
    entry_t   rd_data;
    logic     out_can_load;
    logic     rsp_load;
    rsp_t     rsp_data;

    idafl_store #(
        .MAX_ID (MAX_ID)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .stat_wr (stat_wr),
        .link_wr (link_wr),
        .rd_data (rd_data)
    );

    idafl_ctrl #(
        .MAX_ID (MAX_ID)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rd           (rd),
        .stat_wr      (stat_wr),
        .link_wr      (link_wr),
        .rd_data      (rd_data),
        .out_can_load (out_can_load),
        .rsp_load     (rsp_load),
        .rsp_data     (rsp_data)
    );

    idafl_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (rsp_load),
        .data     (rsp_data),
        .can_load (out_can_load),
        .rsp      (rsp)
    );

endmodule

// File: sv/idafl_store.sv
// ----------------------------------------------------------------------------
// idafl_store
// Entry memories: status flags with backward link, and forward link.
// ----------------------------------------------------------------------------
module idafl_store
    import idafl_pkg::*;
#(
    parameter int MAX_ID = MAX_ID_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  rd_req_t  rd,
    input  stat_wr_t stat_wr,
    input  link_wr_t link_wr,
    output entry_t   rd_data
);

    localparam int LAST  = (MAX_ID < ID_LIMIT) ? MAX_ID : ID_LIMIT;
    localparam int TBL   = LAST + 1;
    localparam int IDX_W = $clog2(TBL);

    logic [IDX_W+1:0] stat_mem [TBL];
    logic [IDX_W-1:0] link_mem [TBL];

    // One valid bit per entry stands in for the all-zero reset of the flags.
    logic [TBL-1:0]   valid_reg;
    logic             vld_q_reg;
    logic [IDX_W+1:0] stat_q_reg;
    logic [IDX_W-1:0] link_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (stat_wr.en)
            begin
                valid_reg[stat_wr.addr[IDX_W-1:0]] <= 1'b1;
            end
            if (rd.en)
            begin
                vld_q_reg <= valid_reg[rd.addr[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat_wr.en)
        begin
            stat_mem[stat_wr.addr[IDX_W-1:0]] <=
                {stat_wr.assigned, stat_wr.on_free, stat_wr.prev[IDX_W-1:0]};
        end
        if (rd.en)
        begin
            stat_q_reg <= stat_mem[rd.addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_wr.en)
        begin
            link_mem[link_wr.addr[IDX_W-1:0]] <= link_wr.next[IDX_W-1:0];
        end
        if (rd.en)
        begin
            link_q_reg <= link_mem[rd.addr[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        rd_data.assigned = vld_q_reg & stat_q_reg[IDX_W+1];
        rd_data.on_free  = vld_q_reg & stat_q_reg[IDX_W];
        rd_data.prev     = ID_W'(stat_q_reg[IDX_W-1:0]);
        rd_data.next     = ID_W'(link_q_reg);
    end

endmodule

// File: sv/idafl_out_reg.sv
// ----------------------------------------------------------------------------
// idafl_out_reg
// Result register that holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
module idafl_out_reg
    import idafl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  rsp_t  data,
    output logic  can_load,
    idafl_rsp_if.source rsp
);

    logic valid_reg;
    rsp_t data_reg;

    assign can_load = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= data;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.freed        = data_reg.freed;
    assign rsp.is_assigned  = data_reg.is_assigned;
    assign rsp.is_available = data_reg.is_available;
    assign rsp.next_id      = data_reg.next_id;
    assign rsp.highest_id   = data_reg.highest_id;

endmodule

// File: sv/idafl_ctrl.sv
// ----------------------------------------------------------------------------
// idafl_ctrl
// Sequencer that reads an entry, updates the free list and builds the result.
// ----------------------------------------------------------------------------
module idafl_ctrl
    import idafl_pkg::*;
#(
    parameter int MAX_ID = MAX_ID_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    idafl_req_if.sink req,
    output rd_req_t  rd,
    output stat_wr_t stat_wr,
    output link_wr_t link_wr,
    input  entry_t   rd_data,
    input  logic     out_can_load,
    output logic     rsp_load,
    output rsp_t     rsp_data
);

`include "id_allocator_free_list_top_assert.svh"

    localparam int LAST  = (MAX_ID < ID_LIMIT) ? MAX_ID : ID_LIMIT;
    localparam int TBL   = LAST + 1;
    localparam int IDX_W = $clog2(TBL);
    localparam int CNT_W = $clog2(TBL + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_SKIP  = 5'b00100,
        S_CLAIM = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] highest_reg, highest_next;
    logic [IDX_W-1:0] skip_reg, skip_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             freed_reg, freed_next;
    logic             asg_reg, asg_next;
    logic             fr_reg, fr_next;
    logic [1:0]       func_reg, func_next;
    logic [ID_W-1:0]  id_reg, id_next;

    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] ent_prev;
    logic [IDX_W-1:0] ent_next;

    assign in_range  = id_reg <= ID_W'(LAST);
    assign idx       = id_reg[IDX_W-1:0];
    assign ent_prev  = rd_data.prev[IDX_W-1:0];
    assign ent_next  = rd_data.next[IDX_W-1:0];
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        highest_next = highest_reg;
        skip_next    = skip_reg;
        count_next   = count_reg;
        freed_next   = freed_reg;
        asg_next     = asg_reg;
        fr_next      = fr_reg;
        func_next    = func_reg;
        id_next      = id_reg;
        rd           = '0;
        stat_wr      = '0;
        link_wr      = '0;
        rsp_load     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    id_next    = req.id;
                    rd.en      = 1'b1;
                    rd.addr    = req.id;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                asg_next   = in_range & rd_data.assigned;
                fr_next    = in_range & rd_data.on_free;
                freed_next = 1'b0;
                state_next = S_DONE;
                if (in_range && func_reg == FUNC_CLAIM)
                begin
                    asg_next   = 1'b1;
                    fr_next    = 1'b0;
                    state_next = S_CLAIM;
                    if (idx > highest_reg)
                    begin
                        skip_next = highest_reg + IDX_W'(1);
                        if (highest_reg + IDX_W'(1) != idx)
                        begin
                            state_next = S_SKIP;
                        end
                    end
                    else if (rd_data.on_free)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        priority if (count_reg <= CNT_W'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (idx == head_reg)
                        begin
                            head_next = ent_next;
                        end
                        else if (idx == tail_reg)
                        begin
                            tail_next = ent_prev;
                        end
                        else
                        begin
                            // Middle of the list: the successor is known to be
                            // free and unassigned, so its flags need no read.
                            link_wr.en       = 1'b1;
                            link_wr.addr     = ID_W'(ent_prev);
                            link_wr.next     = ID_W'(ent_next);
                            stat_wr.en       = 1'b1;
                            stat_wr.addr     = ID_W'(ent_next);
                            stat_wr.assigned = 1'b0;
                            stat_wr.on_free  = 1'b1;
                            stat_wr.prev     = ID_W'(ent_prev);
                        end
                    end
                end
                else if (in_range && func_reg == FUNC_RELEASE && rd_data.assigned)
                begin
                    freed_next       = 1'b1;
                    asg_next         = 1'b0;
                    fr_next          = 1'b1;
                    stat_wr.en       = 1'b1;
                    stat_wr.addr     = id_reg;
                    stat_wr.assigned = 1'b0;
                    stat_wr.on_free  = 1'b1;
                    stat_wr.prev     = rd_data.on_free ? rd_data.prev : ID_W'(tail_reg);
                    if (!rd_data.on_free)
                    begin
                        if (count_reg != '0)
                        begin
                            link_wr.en   = 1'b1;
                            link_wr.addr = ID_W'(tail_reg);
                            link_wr.next = id_reg;
                        end
                        else
                        begin
                            head_next = idx;
                        end
                        tail_next  = idx;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_SKIP:
            begin
                // Append one skipped identifier per cycle.
                stat_wr.en       = 1'b1;
                stat_wr.addr     = ID_W'(skip_reg);
                stat_wr.assigned = 1'b0;
                stat_wr.on_free  = 1'b1;
                stat_wr.prev     = ID_W'(tail_reg);
                if (count_reg != '0)
                begin
                    link_wr.en   = 1'b1;
                    link_wr.addr = ID_W'(tail_reg);
                    link_wr.next = ID_W'(skip_reg);
                end
                else
                begin
                    head_next = skip_reg;
                end
                tail_next  = skip_reg;
                count_next = count_reg + CNT_W'(1);
                skip_next  = skip_reg + IDX_W'(1);
                if (skip_reg + IDX_W'(1) == idx)
                begin
                    state_next = S_CLAIM;
                end
            end
            S_CLAIM:
            begin
                stat_wr.en       = 1'b1;
                stat_wr.addr     = id_reg;
                stat_wr.assigned = 1'b1;
                stat_wr.on_free  = 1'b0;
                stat_wr.prev     = ID_W'(tail_reg);
                if (idx > highest_reg)
                begin
                    highest_next = idx;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_can_load)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_data.freed        = freed_reg;
        rsp_data.is_assigned  = asg_reg;
        rsp_data.is_available = in_range && ((idx > highest_reg) || fr_reg);
        rsp_data.next_id      = (count_reg != '0) ? NEXT_W'(head_reg)
                                                  : NEXT_W'(highest_reg) + NEXT_W'(1);
        rsp_data.highest_id   = ID_W'(highest_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            highest_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            highest_reg <= highest_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skip_reg  <= skip_next;
        freed_reg <= freed_next;
        asg_reg   <= asg_next;
        fr_reg    <= fr_next;
        func_reg  <= func_next;
        id_reg    <= id_next;
    end

    // Skipped identifiers join the list before the highest is raised.
    `IDAFL_ASSERT(a_count_bound, (state_reg == S_SKIP) || (state_reg == S_CLAIM) || (NEXT_W'(count_reg) <= NEXT_W'(highest_reg) + NEXT_W'(1)), "free list too long")
    `IDAFL_ASSERT(a_empty_ptrs, (count_reg != '0) || (head_reg == '0 && tail_reg == '0), "empty free list with stale head or tail")
    `IDAFL_ASSERT_NEXT(a_skip_grows, state_reg == S_SKIP, count_reg == $past(count_reg) + CNT_W'(1), "skipped identifier not appended")
    `IDAFL_ASSERT(a_skip_below, (state_reg != S_SKIP) || (skip_reg < idx && skip_reg > highest_reg), "skip index outside the skipped range")
    `IDAFL_ASSERT_NEXT(a_accept_look, req.valid && req.ready, state_reg == S_LOOK, "accepted beat did not start a lookup")

endmodule
